### hw/rtl/rxps_pkg.sv
package rxps_pkg;

  typedef logic [7:0] key_byte_t;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_START = 2'd1,
    REQ_DATA  = 2'd2
  } req_e;

  localparam key_byte_t KeyPercent = 8'h25;
  localparam key_byte_t KeyDot     = 8'h2e;

  // Key bytes outside 7-bit ASCII and the percent sign are replaced by a dot.
  function automatic key_byte_t clean_key(input key_byte_t c);
    if (c[7] || (c == KeyPercent)) begin
      return KeyDot;
    end
    return c;
  endfunction

endpackage

### hw/rtl/rolling_xor_packet_scrambler.sv
// The result of a data item is registered into the output register when the item is accepted.
// Throughput: one item per cycle while the output is not stalled; the key store is read every cycle
// at the next pointer, so the key byte for the following data item is already registered when it arrives.
// Reset clears the key pointer, running mask, shift phase, challenge and output valid.
// The key store is not cleared; there is no clearing pass after reset.
module rolling_xor_packet_scrambler #(
  parameter int unsigned KEY_LEN = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] req_type_i,
  input  logic [9:0] key_index_i,
  input  logic [7:0] key_byte_i,
  input  logic [7:0] seed_a_i,
  input  logic [7:0] seed_b_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o
);

  localparam int unsigned AW = $clog2(KEY_LEN);
  localparam logic [AW-1:0] PosLast = AW'(KEY_LEN - 1);

  logic [AW-1:0] pos_q, pos_d;
  logic [7:0]    mask_q, mask_d;
  logic          phase_q, phase_d;
  logic [7:0]    challenge_q;
  rxps_pkg::key_byte_t key0_q;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_byte_q, out_byte_d;

  logic                in_acc;
  logic                load_en;
  logic [AW-1:0]       load_addr;
  rxps_pkg::key_byte_t key_cur;
  rxps_pkg::key_byte_t key_sel;
  rxps_pkg::key_byte_t key_clean;
  logic [AW-1:0]       pos_use;
  logic [7:0]          fold;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign load_en    = in_acc && (req_type_i == rxps_pkg::REQ_LOAD) &&
                      (32'(key_index_i) < KEY_LEN);
  assign load_addr  = AW'(key_index_i);

  rxps_key_mem #(
    .DEPTH(KEY_LEN)
  ) u_key_mem (
    .clk_i  (clk_i),
    .we_i   (load_en),
    .waddr_i(load_addr),
    .wdata_i(key_byte_i),
    .raddr_i(pos_d),
    .rdata_o(key_cur)
  );

  always_ff @(posedge clk_i) begin
    if (load_en && (load_addr == '0)) begin
      key0_q <= key_byte_i;
    end
  end

  always_comb begin
    if (key_cur == 8'h00) begin
      key_sel = key0_q;
      pos_use = '0;
    end else begin
      key_sel = key_cur;
      pos_use = pos_q;
    end
    key_clean = rxps_pkg::clean_key(key_sel);
    fold      = phase_q ? {key_clean[6:0], 1'b0} : key_clean;
  end

  always_comb begin
    pos_d       = pos_q;
    mask_d      = mask_q;
    phase_d     = phase_q;
    out_byte_d  = out_byte_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (in_acc) begin
      case (req_type_i)
        rxps_pkg::REQ_START: begin
          mask_d  = seed_a_i ^ seed_b_i ^ challenge_q;
          pos_d   = '0;
          phase_d = 1'b0;
        end
        rxps_pkg::REQ_DATA: begin
          mask_d      = mask_q ^ fold;
          out_byte_d  = data_byte_i ^ mask_d;
          out_valid_d = 1'b1;
          pos_d       = (pos_use == PosLast) ? '0 : pos_use + 1'b1;
          phase_d     = !phase_q;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      mask_q      <= '0;
      phase_q     <= 1'b0;
      challenge_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      mask_q      <= mask_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        challenge_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;

`ifndef SYNTH
  a_data_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (req_type_i == rxps_pkg::REQ_DATA) |=> out_valid_o)
    else $error("data item did not produce a result");

  a_start_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (req_type_i == rxps_pkg::REQ_START) |=> (pos_q == '0) && !phase_q)
    else $error("start item did not rewind pointer and phase");

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pos_q) < KEY_LEN)
    else $error("key pointer out of range");

  a_load_keeps_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (req_type_i == rxps_pkg::REQ_LOAD) |=> $stable(mask_q) && $stable(phase_q))
    else $error("load item changed the running mask");
`endif

endmodule

### hw/rtl/rxps_key_mem.sv
module rxps_key_mem #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  rxps_pkg::key_byte_t      wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output rxps_pkg::key_byte_t      rdata_o
);

  rxps_pkg::key_byte_t mem [DEPTH];
  rxps_pkg::key_byte_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // A write to the entry being read in the same cycle is returned directly.
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
